// ----- sv/software_timer_bank_defines.svh -----
// assertion macros shared by the timer bank modules
`ifndef SOFTWARE_TIMER_BANK_DEFINES_SVH
`define SOFTWARE_TIMER_BANK_DEFINES_SVH

// same-cycle implication, checked on clk and held off during reset
`define STB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk and held off during reset
`define STB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/stb_pkg.sv -----
// shared constants, codes and controller/datapath types for the timer bank
package stb_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int OWNER_BITS = 8;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int TICK_W     = 31;
  localparam int RATIO_W    = 17;
  localparam int PROD_W     = 32 + RATIO_W;

  localparam logic [RATIO_W-1:0] RATIO_RESET   = 17'd65072;
  localparam logic [TICK_W-1:0]  TICK_MAX      = 31'h7FFF_FFFF;
  localparam logic [31:0]        MS_LIMIT      = 32'd2162687832;
  localparam logic [31:0]        MS_NO_ELAPSED = 32'h8000_0000;
  localparam logic [31:0]        REFRESH_MASK  = 32'h0000_FFFF;

  localparam logic signed [1:0] CMP_LESS    = -2'sd1;
  localparam logic signed [1:0] CMP_EQUAL   = 2'sd0;
  localparam logic signed [1:0] CMP_GREATER = 2'sd1;

  typedef enum logic [2:0] {
    REQ_TICK        = 3'd0,
    REQ_RD_ELAPSED  = 3'd1,
    REQ_CLR_ELAPSED = 3'd2,
    REQ_START       = 3'd3,
    REQ_STOP        = 3'd4,
    REQ_REFRESH     = 3'd5,
    REQ_RD_REMAIN   = 3'd6,
    REQ_COMPARE     = 3'd7
  } req_kind_t;

  typedef enum logic [2:0] {
    EVT_ACK          = 3'd0,
    EVT_EXP_QUIET    = 3'd1,
    EVT_EXP_WAKE     = 3'd2,
    EVT_EXP_HANDLER  = 3'd3,
    EVT_STOP_WAKE    = 3'd4,
    EVT_STOP_HANDLER = 3'd5,
    EVT_VALUE        = 3'd6
  } evt_kind_t;

  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_WAKE    = 2'd1,
    MODE_HANDLER = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SINGLE,
    OP_ST_ADD,
    OP_ST_MUL,
    OP_ST_WR,
    OP_CMP_A,
    OP_CMP_B,
    OP_RF_INIT,
    OP_RF_STEP,
    OP_RF_END
  } dp_op_t;

  typedef enum logic [1:0] {
    ADDR_SLOT,
    ADDR_OTHER,
    ADDR_WALK
  } addr_sel_t;

  typedef struct packed {
    dp_op_t    op;
    addr_sel_t addr;
    logic      in_ready;
  } dp_cmd_t;

  typedef struct packed {
    logic      in_valid;
    req_kind_t req;
    logic      start_go;
    logic      out_free;
    logic      rf_expire;
    logic      pend_valid;
    logic      walk_last;
  } dp_status_t;

endpackage

// ----- sv/stb_if.sv -----
// request, event and ratio-write channels of the timer bank

interface stb_req_if import stb_pkg::*; ();
  logic        valid;
  logic        ready;
  req_kind_t   req_type;
  logic [3:0]  slot;
  logic [3:0]  other_slot;
  logic [31:0] value;
  logic [7:0]  owner_id;
  logic        with_listener;
  logic        with_handler;
  logic        notify_on_stop;

  modport source (
    output valid, req_type, slot, other_slot, value, owner_id,
           with_listener, with_handler, notify_on_stop,
    input  ready
  );
  modport sink (
    input  valid, req_type, slot, other_slot, value, owner_id,
           with_listener, with_handler, notify_on_stop,
    output ready
  );
endinterface

interface stb_evt_if import stb_pkg::*; ();
  logic               valid;
  logic               ready;
  evt_kind_t          event_kind;
  logic [3:0]         event_slot;
  logic [7:0]         event_owner;
  logic [31:0]        read_value;
  logic signed [1:0]  compare_result;
  logic               last;

  modport source (
    output valid, event_kind, event_slot, event_owner, read_value,
           compare_result, last,
    input  ready
  );
  modport sink (
    input  valid, event_kind, event_slot, event_owner, read_value,
           compare_result, last,
    output ready
  );
endinterface

interface stb_cfg_if import stb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RATIO_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- sv/stb_ctrl.sv -----
// sequencing state machine of the timer bank
`include "software_timer_bank_defines.svh"

module stb_ctrl import stb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SINGLE,
    S_ST_ADD,
    S_ST_MUL,
    S_ST_WR,
    S_CMP_A,
    S_CMP_B,
    S_RF_WALK,
    S_RF_END
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r;

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_NONE;
    cmd.in_ready = ready_r;
    case (state_r)
      S_CMP_B:   cmd.addr = ADDR_OTHER;
      S_RF_WALK: cmd.addr = ADDR_WALK;
      default:   cmd.addr = ADDR_SLOT;
    endcase

    case (state_r)
      S_IDLE: begin
        if (status.in_valid && ready_r) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.req)
          REQ_START:   state_nxt = status.start_go ? S_ST_ADD : S_SINGLE;
          REQ_COMPARE: state_nxt = S_CMP_A;
          REQ_REFRESH: begin
            cmd.op    = OP_RF_INIT;
            state_nxt = S_RF_WALK;
          end
          default:     state_nxt = S_SINGLE;
        endcase
      end
      S_SINGLE: begin
        if (status.out_free) begin
          cmd.op    = OP_SINGLE;
          state_nxt = S_IDLE;
        end
      end
      S_ST_ADD: begin
        cmd.op    = OP_ST_ADD;
        state_nxt = S_ST_MUL;
      end
      S_ST_MUL: begin
        cmd.op    = OP_ST_MUL;
        state_nxt = S_ST_WR;
      end
      S_ST_WR: begin
        if (status.out_free) begin
          cmd.op    = OP_ST_WR;
          state_nxt = S_IDLE;
        end
      end
      S_CMP_A: begin
        cmd.op    = OP_CMP_A;
        state_nxt = S_CMP_B;
      end
      S_CMP_B: begin
        if (status.out_free) begin
          cmd.op    = OP_CMP_B;
          state_nxt = S_IDLE;
        end
      end
      S_RF_WALK: begin
        // an expiry must push the held event out first
        if (!(status.rf_expire && status.pend_valid && !status.out_free)) begin
          cmd.op = OP_RF_STEP;
          if (status.walk_last) state_nxt = S_RF_END;
        end
      end
      S_RF_END: begin
        if (status.out_free) begin
          cmd.op    = OP_RF_END;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      ready_r <= (state_nxt == S_IDLE);
    end
  end

  `STB_ASSERT_IMPL(a_ready_only_idle, ready_r, state_r == S_IDLE, "ready outside idle")
  `STB_ASSERT_NEXT(a_walk_ends, (state_r == S_RF_WALK) && (cmd.op == OP_RF_STEP) && status.walk_last, state_r == S_RF_END, "refresh walk did not end")

endmodule

// ----- sv/stb_datapath.sv -----
// slot store, elapsed counter, tick conversion and event register of the timer bank
`include "software_timer_bank_defines.svh"

module stb_datapath import stb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  stb_req_if.sink    in_req,
  stb_evt_if.source  out_evt,
  stb_cfg_if.sink    cfg_wr,
  input  dp_cmd_t    cmd,
  output dp_status_t status
);

  // slot state
  logic [TICK_W-1:0]     ticks_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  act_r;
  mode_t                 mode_r  [NUM_SLOTS];
  logic [OWNER_BITS-1:0] own_r   [NUM_SLOTS];
  logic [15:0]           elapsed_r;
  logic [RATIO_W-1:0]    ratio_r;

  // captured request
  req_kind_t   rq_kind_r;
  logic [3:0]  rq_slot_r;
  logic [3:0]  rq_other_r;
  logic [31:0] rq_val_r;
  logic [7:0]  rq_owner_r;
  logic        rq_lis_r;
  logic        rq_hnd_r;
  logic        rq_nstop_r;

  // conversion and compare
  logic [31:0]           ms_r;
  logic [PROD_W-1:0]     prod_r;
  logic                  sat_r;
  logic [TICK_W-1:0]     cmp_a_r;
  logic [OWNER_BITS-1:0] cmp_own_r;

  // refresh walk and held expiry
  logic [SLOT_W-1:0]     walk_r;
  logic                  pend_valid_r;
  evt_kind_t             pend_kind_r;
  logic [SLOT_W-1:0]     pend_slot_r;
  logic [OWNER_BITS-1:0] pend_own_r;

  // event register
  logic              out_valid_r;
  evt_kind_t         out_kind_r;
  logic [3:0]        out_slot_r;
  logic [7:0]        out_owner_r;
  logic [31:0]       out_val_r;
  logic signed [1:0] out_cmp_r;
  logic              out_last_r;

  logic                  slot_ok, other_ok, out_free, expire;
  logic [SLOT_W-1:0]     slot_idx, other_idx, rd_idx;
  logic [TICK_W-1:0]     rd_ticks, t_ext, new_ticks;
  logic                  rd_act;
  mode_t                 rd_mode, new_mode;
  logic [OWNER_BITS-1:0] rd_own, new_own;
  logic [7:0]            s_owner;
  logic [31:0]           sum_ms;
  evt_kind_t             exp_kind;

  logic              emit, e_last;
  evt_kind_t         e_kind;
  logic [3:0]        e_slot;
  logic [7:0]        e_owner;
  logic [31:0]       e_val;
  logic signed [1:0] e_cmp;
  logic              wr_en, wr_act, wr_cfg_en;
  logic [TICK_W-1:0] wr_ticks;

  assign slot_ok   = 32'(rq_slot_r) < NUM_SLOTS;
  assign other_ok  = 32'(rq_other_r) < NUM_SLOTS;
  assign slot_idx  = SLOT_W'(rq_slot_r);
  assign other_idx = SLOT_W'(rq_other_r);

  always_comb begin
    case (cmd.addr)
      ADDR_OTHER: rd_idx = other_idx;
      ADDR_WALK:  rd_idx = walk_r;
      default:    rd_idx = slot_idx;
    endcase
  end

  assign rd_ticks = ticks_r[rd_idx];
  assign rd_act   = act_r[rd_idx];
  assign rd_mode  = mode_r[rd_idx];
  assign rd_own   = own_r[rd_idx];
  assign s_owner  = slot_ok ? 8'(rd_own) : 8'd0;

  assign t_ext  = TICK_W'(rq_val_r & REFRESH_MASK);
  assign expire = rd_act && (rd_ticks <= t_ext);

  always_comb begin
    case (rd_mode)
      MODE_WAKE:    exp_kind = EVT_EXP_WAKE;
      MODE_HANDLER: exp_kind = EVT_EXP_HANDLER;
      default:      exp_kind = EVT_EXP_QUIET;
    endcase
  end

  // a set top bit means the elapsed count is not added
  assign sum_ms = rq_val_r +
                  (((rq_val_r & MS_NO_ELAPSED) == 32'd0) ? 32'(elapsed_r) : 32'd0);

  assign new_ticks = (sat_r || (prod_r[PROD_W-1:TICK_W+16] != '0)) ?
                     TICK_MAX : prod_r[TICK_W+15:16];
  assign new_mode  = rq_lis_r ? MODE_WAKE : (rq_hnd_r ? MODE_HANDLER : MODE_NONE);
  assign new_own   = rq_lis_r ? OWNER_BITS'(rq_owner_r) : '0;

  assign out_free = !out_valid_r || out_evt.ready;

  always_comb begin
    emit      = 1'b0;
    e_kind    = EVT_ACK;
    e_slot    = 4'd0;
    e_owner   = 8'd0;
    e_val     = 32'd0;
    e_cmp     = CMP_EQUAL;
    e_last    = 1'b1;
    wr_en     = 1'b0;
    wr_act    = 1'b0;
    wr_ticks  = '0;
    wr_cfg_en = 1'b0;
    case (cmd.op)
      OP_SINGLE: begin
        emit = 1'b1;
        case (rq_kind_r)
          REQ_RD_ELAPSED: begin
            e_kind = EVT_VALUE;
            e_val  = 32'(elapsed_r);
          end
          REQ_START: begin
            e_slot  = rq_slot_r;
            e_owner = s_owner;
          end
          REQ_STOP: begin
            e_slot  = rq_slot_r;
            e_owner = s_owner;
            if (slot_ok && rd_act) begin
              wr_en = 1'b1;
              if (rq_nstop_r) begin
                case (rd_mode)
                  MODE_WAKE:    e_kind = EVT_STOP_WAKE;
                  MODE_HANDLER: e_kind = EVT_STOP_HANDLER;
                  default:      e_kind = EVT_ACK;
                endcase
              end
            end
          end
          REQ_RD_REMAIN: begin
            e_kind  = EVT_VALUE;
            e_slot  = rq_slot_r;
            e_owner = s_owner;
            e_val   = slot_ok ? 32'(rd_ticks) : 32'd0;
          end
          default: e_kind = EVT_ACK;
        endcase
      end
      OP_ST_WR: begin
        emit      = 1'b1;
        e_slot    = rq_slot_r;
        e_owner   = 8'(new_own);
        wr_en     = 1'b1;
        wr_act    = 1'b1;
        wr_ticks  = new_ticks;
        wr_cfg_en = 1'b1;
      end
      OP_CMP_B: begin
        emit    = 1'b1;
        e_kind  = EVT_VALUE;
        e_slot  = rq_slot_r;
        e_owner = slot_ok ? 8'(cmp_own_r) : 8'd0;
        if (slot_ok && other_ok) begin
          if (cmp_a_r < rd_ticks)      e_cmp = CMP_LESS;
          else if (cmp_a_r > rd_ticks) e_cmp = CMP_GREATER;
          else                         e_cmp = CMP_EQUAL;
        end
      end
      OP_RF_STEP: begin
        if (rd_act) begin
          wr_en = 1'b1;
          if (expire) begin
            // the held expiry is known not to be the final one now
            if (pend_valid_r) begin
              emit    = 1'b1;
              e_kind  = pend_kind_r;
              e_slot  = 4'(pend_slot_r);
              e_owner = 8'(pend_own_r);
              e_last  = 1'b0;
            end
          end else begin
            wr_act   = 1'b1;
            wr_ticks = rd_ticks - t_ext;
          end
        end
      end
      OP_RF_END: begin
        emit = 1'b1;
        if (pend_valid_r) begin
          e_kind  = pend_kind_r;
          e_slot  = 4'(pend_slot_r);
          e_owner = 8'(pend_own_r);
        end
      end
      default: emit = 1'b0;
    endcase
  end

  // control state and slot store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        ticks_r[i] <= '0;
        mode_r[i]  <= MODE_NONE;
        own_r[i]   <= '0;
      end
      act_r        <= '0;
      elapsed_r    <= 16'd0;
      ratio_r      <= RATIO_RESET;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      walk_r       <= '0;
    end else begin
      if (cfg_wr.valid) ratio_r <= cfg_wr.data;

      if (cmd.op == OP_SINGLE && rq_kind_r == REQ_TICK)        elapsed_r <= elapsed_r + 16'd1;
      if (cmd.op == OP_SINGLE && rq_kind_r == REQ_CLR_ELAPSED) elapsed_r <= 16'd0;

      if (wr_en) begin
        ticks_r[rd_idx] <= wr_ticks;
        act_r[rd_idx]   <= wr_act;
      end
      if (wr_cfg_en) begin
        mode_r[rd_idx] <= new_mode;
        own_r[rd_idx]  <= new_own;
      end

      if (emit)               out_valid_r <= 1'b1;
      else if (out_evt.ready) out_valid_r <= 1'b0;

      case (cmd.op)
        OP_RF_INIT: begin
          walk_r       <= '0;
          pend_valid_r <= 1'b0;
        end
        OP_RF_STEP: begin
          walk_r <= SLOT_W'(walk_r + 1'b1);
          if (expire) pend_valid_r <= 1'b1;
        end
        OP_RF_END: pend_valid_r <= 1'b0;
        default: pend_valid_r <= pend_valid_r;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      rq_kind_r  <= in_req.req_type;
      rq_slot_r  <= in_req.slot;
      rq_other_r <= in_req.other_slot;
      rq_val_r   <= in_req.value;
      rq_owner_r <= in_req.owner_id;
      rq_lis_r   <= in_req.with_listener;
      rq_hnd_r   <= in_req.with_handler;
      rq_nstop_r <= in_req.notify_on_stop;
    end
    if (cmd.op == OP_ST_ADD) ms_r <= sum_ms;
    if (cmd.op == OP_ST_MUL) begin
      prod_r <= PROD_W'(ms_r) * PROD_W'(ratio_r);
      sat_r  <= (ms_r >= MS_LIMIT);
    end
    if (cmd.op == OP_CMP_A) begin
      cmp_a_r   <= rd_ticks;
      cmp_own_r <= rd_own;
    end
    if (cmd.op == OP_RF_STEP && expire) begin
      pend_kind_r <= exp_kind;
      pend_slot_r <= walk_r;
      pend_own_r  <= rd_own;
    end
    if (emit) begin
      out_kind_r  <= e_kind;
      out_slot_r  <= e_slot;
      out_owner_r <= e_owner;
      out_val_r   <= e_val;
      out_cmp_r   <= e_cmp;
      out_last_r  <= e_last;
    end
  end

  assign in_req.ready          = cmd.in_ready;
  assign cfg_wr.ready          = 1'b1;
  assign out_evt.valid          = out_valid_r;
  assign out_evt.event_kind     = out_kind_r;
  assign out_evt.event_slot     = out_slot_r;
  assign out_evt.event_owner    = out_owner_r;
  assign out_evt.read_value     = out_val_r;
  assign out_evt.compare_result = out_cmp_r;
  assign out_evt.last           = out_last_r;

  assign status.in_valid   = in_req.valid;
  assign status.req        = rq_kind_r;
  assign status.start_go   = slot_ok && (rq_val_r != 32'd0);
  assign status.out_free   = out_free;
  assign status.rf_expire  = expire;
  assign status.pend_valid = pend_valid_r;
  assign status.walk_last  = (walk_r == SLOT_W'(NUM_SLOTS - 1));

  `STB_ASSERT_IMPL(a_emit_into_free, emit, !out_valid_r || out_evt.ready, "event register overwritten")
  `STB_ASSERT_NEXT(a_end_drops_pend, cmd.op == OP_RF_END, !pend_valid_r, "held expiry survived refresh end")
  `STB_ASSERT_NEXT(a_start_arms_slot, cmd.op == OP_ST_WR, act_r[slot_idx], "started slot not active")

endmodule

// ----- sv/software_timer_bank.sv -----
// Software timer bank: sixteen countdown slots and a 16-bit elapsed-tick counter behind a
// request channel, an event channel and a write port for the Q1.16 ticks-per-ms ratio. One
// request is taken at a time; it is accepted while the previous event still waits in the
// output register. Tick, elapsed read/clear, stop and read remaining pass through decode
// and a single step that writes the event register; a start with a non-zero time adds
// elapsed, does a 32x17 multiply, saturates and stores, and a compare makes two reads through
// the single read port of the slot store. A refresh visits one slot per cycle through that
// port while it is not stalled: an expiry found while an earlier one is still held and the
// event register is full waits in the walk until the register drains. Back-pressure on the
// event channel adds its stall cycles. Reset clears all slots at once; there is no clearing
// pass. The ratio register may be written at any time the bank is idle.
module software_timer_bank import stb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  stb_req_if.sink   in_req,
  stb_evt_if.source out_evt,
  stb_cfg_if.sink   cfg_wr
);

  dp_cmd_t    cmd;
  dp_status_t status;

  stb_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  stb_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_evt (out_evt),
    .cfg_wr  (cfg_wr),
    .cmd     (cmd),
    .status  (status)
  );

endmodule

// ----- tb/tb_software_timer_bank.sv -----
// self-checking testbench for the software timer bank: directed and random requests
`timescale 1ns / 100ps

module tb_software_timer_bank import stb_pkg::*; ();

  localparam int IDLE_PCT      = 36;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    req_kind_t   kind;
    logic [3:0]  slot;
    logic [3:0]  other_slot;
    logic [31:0] value;
    logic [7:0]  owner_id;
    logic        with_listener;
    logic        with_handler;
    logic        notify_on_stop;
  } timer_req_t;

  typedef struct {
    evt_kind_t         kind;
    logic [3:0]        slot;
    logic [7:0]        owner;
    logic [31:0]       value;
    logic signed [1:0] cmp;
    logic              last;
  } timer_evt_t;

  class event_scoreboard;
    logic [TICK_W-1:0]     remaining [NUM_SLOTS];
    logic                  armed [NUM_SLOTS];
    mode_t                 mode [NUM_SLOTS];
    logic [OWNER_BITS-1:0] owner [NUM_SLOTS];
    logic [15:0]           elapsed;
    logic [RATIO_W-1:0]    ratio;
    timer_evt_t            pending_events [$];
    int                    mismatches;

    function new();
      ratio      = RATIO_RESET;
      elapsed    = '0;
      mismatches = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        remaining[i] = '0;
        armed[i]     = 1'b0;
        mode[i]      = MODE_NONE;
        owner[i]     = '0;
      end
    endfunction

    function void push_event(evt_kind_t kind, logic [3:0] slot, logic [7:0] who,
                             logic [31:0] value, logic signed [1:0] cmp);
      timer_evt_t e;
      e.kind  = kind;
      e.slot  = slot;
      e.owner = who;
      e.value = value;
      e.cmp   = cmp;
      e.last  = 1'b0;
      pending_events.push_back(e);
    endfunction

    // works out the events of one accepted request and updates the slot state
    function void note_request(timer_req_t r);
      logic [31:0]       ms;
      logic [48:0]       product;
      logic [TICK_W-1:0] ticks;
      logic [7:0]        old_owner;
      evt_kind_t         kind;
      logic signed [1:0] order;
      int                fired;
      old_owner = owner[r.slot];
      fired     = 0;
      case (r.kind)
        REQ_TICK: begin
          elapsed = elapsed + 16'd1;
          push_event(EVT_ACK, '0, '0, '0, CMP_EQUAL);
        end
        REQ_RD_ELAPSED: begin
          push_event(EVT_VALUE, '0, '0, {16'd0, elapsed}, CMP_EQUAL);
        end
        REQ_CLR_ELAPSED: begin
          elapsed = '0;
          push_event(EVT_ACK, '0, '0, '0, CMP_EQUAL);
        end
        REQ_START: begin
          if (r.value != '0) begin
            ms = r.value;
            if ((ms & MS_NO_ELAPSED) == '0) begin
              ms = ms + {16'd0, elapsed};
            end
            if (ms >= MS_LIMIT) begin
              ticks = TICK_MAX;
            end else begin
              product = ms * ratio;
              if ((product >> 16) > TICK_MAX) ticks = TICK_MAX;
              else ticks = product[16 +: TICK_W];
            end
            if (r.with_listener) begin
              mode[r.slot]  = MODE_WAKE;
              owner[r.slot] = r.owner_id;
            end else if (r.with_handler) begin
              mode[r.slot]  = MODE_HANDLER;
              owner[r.slot] = '0;
            end else begin
              mode[r.slot]  = MODE_NONE;
              owner[r.slot] = '0;
            end
            remaining[r.slot] = ticks;
            armed[r.slot]     = 1'b1;
          end
          push_event(EVT_ACK, r.slot, owner[r.slot], '0, CMP_EQUAL);
        end
        REQ_STOP: begin
          kind = EVT_ACK;
          if (armed[r.slot]) begin
            remaining[r.slot] = '0;
            armed[r.slot]     = 1'b0;
            if (r.notify_on_stop && mode[r.slot] == MODE_WAKE) kind = EVT_STOP_WAKE;
            else if (r.notify_on_stop && mode[r.slot] == MODE_HANDLER) kind = EVT_STOP_HANDLER;
          end
          push_event(kind, r.slot, old_owner, '0, CMP_EQUAL);
        end
        REQ_REFRESH: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (armed[i]) begin
              if (remaining[i] > {15'd0, r.value[15:0]}) begin
                remaining[i] = remaining[i] - {15'd0, r.value[15:0]};
              end else begin
                if (mode[i] == MODE_WAKE) kind = EVT_EXP_WAKE;
                else if (mode[i] == MODE_HANDLER) kind = EVT_EXP_HANDLER;
                else kind = EVT_EXP_QUIET;
                remaining[i] = '0;
                armed[i]     = 1'b0;
                push_event(kind, 4'(i), owner[i], '0, CMP_EQUAL);
                fired++;
              end
            end
          end
          if (fired == 0) push_event(EVT_ACK, '0, '0, '0, CMP_EQUAL);
        end
        REQ_RD_REMAIN: begin
          push_event(EVT_VALUE, r.slot, old_owner, {1'b0, remaining[r.slot]}, CMP_EQUAL);
        end
        default: begin
          if (remaining[r.slot] < remaining[r.other_slot]) order = CMP_LESS;
          else if (remaining[r.slot] > remaining[r.other_slot]) order = CMP_GREATER;
          else order = CMP_EQUAL;
          push_event(EVT_VALUE, r.slot, old_owner, '0, order);
        end
      endcase
      pending_events[pending_events.size()-1].last = 1'b1;
    endfunction

    function void check_event(timer_evt_t got);
      timer_evt_t want;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected event: kind %0d slot %0d owner %0h value %0h cmp %0d last %0b",
                   got.kind, got.slot, got.owner, got.value, got.cmp, got.last);
        return;
      end
      want = pending_events.pop_front();
      if (got.kind !== want.kind || got.slot !== want.slot || got.owner !== want.owner ||
          got.value !== want.value || got.cmp !== want.cmp || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("event mismatch: expected kind %0d slot %0d owner %0h value %0h cmp %0d last %0b",
                   want.kind, want.slot, want.owner, want.value, want.cmp, want.last);
          $display("                actual   kind %0d slot %0d owner %0h value %0h cmp %0d last %0b",
                   got.kind, got.slot, got.owner, got.value, got.cmp, got.last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic quiet;       // no random idling on either side
  int   hold_asked;  // bumped to make the event side hold off for a long stretch

  stb_req_if in_req();
  stb_evt_if out_evt();
  stb_cfg_if cfg_wr();

  event_scoreboard sb;

  software_timer_bank u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_evt (out_evt),
    .cfg_wr  (cfg_wr)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("timeout waiting for the timer bank");
    $display("tb_software_timer_bank: FAIL");
    $finish;
  end

  // event side: checks every beat and drives ready
  initial begin : event_sink
    timer_evt_t seen;
    int         hold_left;
    int         hold_served;
    out_evt.ready = 1'b0;
    hold_left     = 0;
    hold_served   = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_evt.valid && out_evt.ready) begin
        seen.kind  = out_evt.event_kind;
        seen.slot  = out_evt.event_slot;
        seen.owner = out_evt.event_owner;
        seen.value = out_evt.read_value;
        seen.cmp   = out_evt.compare_result;
        seen.last  = out_evt.last;
        sb.check_event(seen);
      end
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_evt.ready <= 1'b0;
      end else if (quiet) begin
        out_evt.ready <= 1'b1;
      end else begin
        out_evt.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  function automatic timer_req_t make_req(req_kind_t kind, logic [3:0] slot,
                                          logic [3:0] other_slot, logic [31:0] value,
                                          logic [7:0] owner_id, logic lis, logic hnd,
                                          logic nstop);
    timer_req_t r;
    r.kind           = kind;
    r.slot           = slot;
    r.other_slot     = other_slot;
    r.value          = value;
    r.owner_id       = owner_id;
    r.with_listener  = lis;
    r.with_handler   = hnd;
    r.notify_on_stop = nstop;
    return r;
  endfunction

  // mostly starts and refreshes with small times so that slots keep expiring
  function automatic timer_req_t random_request();
    timer_req_t r;
    int         roll;
    roll             = $urandom_range(0, 99);
    r.slot           = 4'($urandom_range(0, 15));
    r.other_slot     = 4'($urandom_range(0, 15));
    r.value          = $urandom();
    r.owner_id       = 8'($urandom_range(0, 255));
    r.with_listener  = 1'($urandom_range(0, 1));
    r.with_handler   = 1'($urandom_range(0, 1));
    r.notify_on_stop = 1'($urandom_range(0, 1));
    if (roll < 32) begin
      r.kind = REQ_START;
      case ($urandom_range(0, 11))
        0: r.value = '0;
        1: ;
        2: r.value = MS_NO_ELAPSED | 32'($urandom_range(0, 3000));
        default: r.value = 32'($urandom_range(1, 3000));
      endcase
    end else if (roll < 52) begin
      r.kind = REQ_REFRESH;
      if ($urandom_range(0, 3) == 0) r.value[15:0] = 16'($urandom_range(0, 65535));
      else r.value[15:0] = 16'($urandom_range(0, 600));
    end else if (roll < 60) begin
      r.kind = REQ_TICK;
    end else if (roll < 70) begin
      r.kind = REQ_STOP;
    end else if (roll < 80) begin
      r.kind = REQ_RD_REMAIN;
    end else if (roll < 88) begin
      r.kind = REQ_COMPARE;
    end else if (roll < 95) begin
      r.kind = REQ_RD_ELAPSED;
    end else begin
      r.kind = REQ_CLR_ELAPSED;
    end
    return r;
  endfunction

  task automatic send_request(timer_req_t r);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid          <= 1'b1;
    in_req.req_type       <= r.kind;
    in_req.slot           <= r.slot;
    in_req.other_slot     <= r.other_slot;
    in_req.value          <= r.value;
    in_req.owner_id       <= r.owner_id;
    in_req.with_listener  <= r.with_listener;
    in_req.with_handler   <= r.with_handler;
    in_req.notify_on_stop <= r.notify_on_stop;
    do @(posedge clk); while (!(in_req.valid && in_req.ready));
    sb.note_request(r);
  endtask

  // stop offering and wait until every expected event has come back
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_req.valid <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (sb.pending_events.size() != 0 && guard < DRAIN_LIMIT);
  endtask

  task automatic write_ratio(logic [RATIO_W-1:0] ratio);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.data  <= ratio;
    do @(posedge clk); while (!(cfg_wr.valid && cfg_wr.ready));
    cfg_wr.valid <= 1'b0;
    sb.ratio = ratio;
  endtask

  task automatic run_random(int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 39) == 0) wait_drained();
      send_request(random_request());
    end
  endtask

  initial begin : stimulus
    sb                    = new();
    quiet                 = 1'b0;
    hold_asked            = 0;
    rst_n                 = 1'b0;
    in_req.valid          = 1'b0;
    in_req.req_type       = REQ_TICK;
    in_req.slot           = '0;
    in_req.other_slot     = '0;
    in_req.value          = '0;
    in_req.owner_id       = '0;
    in_req.with_listener  = 1'b0;
    in_req.with_handler   = 1'b0;
    in_req.notify_on_stop = 1'b0;
    cfg_wr.valid          = 1'b0;
    cfg_wr.data           = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass at the reset ratio
    send_request(make_req(REQ_RD_ELAPSED, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_RD_ELAPSED, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_CLR_ELAPSED, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_START, 0, 0, 32'd0, 8'h11, 1, 0, 0));       // zero time ignored
    send_request(make_req(REQ_START, 0, 0, 32'd1, 8'hFF, 1, 0, 0));       // converts to 0 ticks
    send_request(make_req(REQ_START, 15, 0, 32'hFFFF_FFFF, 8'hA5, 0, 1, 0));
    send_request(make_req(REQ_START, 1, 0, MS_LIMIT, 8'h5A, 1, 0, 0));
    send_request(make_req(REQ_START, 2, 0, MS_LIMIT - 1, 8'h00, 0, 0, 0));
    send_request(make_req(REQ_START, 3, 0, 32'd500, 8'h3C, 1, 1, 0));
    send_request(make_req(REQ_START, 4, 0, 32'd40, 8'h77, 0, 1, 0));
    send_request(make_req(REQ_RD_REMAIN, 15, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_RD_REMAIN, 2, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_COMPARE, 1, 15, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_COMPARE, 3, 1, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_COMPARE, 1, 3, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_STOP, 3, 0, 0, 0, 0, 0, 1));
    send_request(make_req(REQ_STOP, 3, 0, 0, 0, 0, 0, 1));               // already stopped
    send_request(make_req(REQ_STOP, 4, 0, 0, 0, 0, 0, 1));
    send_request(make_req(REQ_STOP, 2, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_START, 5, 0, 32'd1, 8'h22, 0, 0, 0));
    send_request(make_req(REQ_REFRESH, 0, 0, 32'd0, 0, 0, 0, 0));         // zero-tick slots expire
    send_request(make_req(REQ_REFRESH, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0)); // nothing expires
    send_request(make_req(REQ_CLR_ELAPSED, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_RD_ELAPSED, 0, 0, 0, 0, 0, 0, 0));

    write_ratio('0);
    run_random(50);

    // largest ratio: arm every slot while the event side holds off, then expire all
    write_ratio({RATIO_W{1'b1}});
    hold_asked++;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      send_request(make_req(REQ_START, 4'(s), 0, 32'($urandom_range(1, 200)),
                            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 0));
    end
    send_request(make_req(REQ_REFRESH, 0, 0, 32'h0000_FFFF, 0, 0, 0, 0));
    send_request(make_req(REQ_START, 7, 0, 32'h7FFF_FFFF, 8'h81, 0, 0, 0)); // product saturates
    send_request(make_req(REQ_RD_REMAIN, 7, 0, 0, 0, 0, 0, 0));
    run_random(50);

    write_ratio(17'd65536);
    quiet = 1'b1;
    run_random(50);
    quiet = 1'b0;

    write_ratio(RATIO_W'($urandom_range(0, 131071)));
    run_random(50);

    // a few ticks, a start that adds the elapsed count, then one more tick
    write_ratio(RATIO_RESET);
    quiet = 1'b1;
    send_request(make_req(REQ_CLR_ELAPSED, 0, 0, 0, 0, 0, 0, 0));
    for (int k = 0; k < 12; k++) send_request(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_RD_ELAPSED, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_START, 9, 0, 32'h7FFF_FFFF, 8'hC3, 1, 0, 0));
    send_request(make_req(REQ_RD_REMAIN, 9, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_RD_ELAPSED, 0, 0, 0, 0, 0, 0, 0));
    quiet = 1'b0;
    run_random(50);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_events.size() == 0) begin
      $display("tb_software_timer_bank: PASS");
    end else begin
      $display("tb_software_timer_bank: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/stb_pkg.sv
sv/stb_if.sv
sv/stb_ctrl.sv
sv/stb_datapath.sv
sv/software_timer_bank.sv
tb/tb_software_timer_bank.sv
